// ===== rtl/wrmswl_pkg.sv =====
// Shared constants, types and codes of the windowed RMS / waveform length core.
package wrmswl_pkg;

    localparam int NCH        = 4;
    localparam int SAMPLE_W   = 16;
    localparam int RMS_W      = 32;
    localparam int WL_W       = 24;
    localparam int CNT_W      = 16;
    localparam int SQ_W       = 48;
    localparam int DIFF_W     = 32;
    localparam int BASE_W     = 24;
    localparam int DIV_NUM_W  = 80;
    localparam int DIV_DEN_W  = 24;
    localparam int SQRT_W     = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int CHANNELS_DEF    = 4;
    localparam int MAX_WINDOW_DEF  = 65535;
    localparam int SAMPLE_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ST_CAL_NOW   = 2'd0,
        ST_CAL_RETRY = 2'd1,
        ST_MEAS      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SAMP,
        B_LAUNCH,
        B_WLDIV,
        B_MDIV,
        B_SQRT,
        B_RDIV,
        B_DONE
    } bstate_t;

    typedef struct packed {
        logic                               is_report;
        logic [NCH-1:0][SAMPLE_W-1:0]       smp;
    } item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic              start;
        logic [SQRT_W-1:0] x;
    } sqrt_req_t;

    typedef struct packed {
        logic             done;
        logic [RMS_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// ===== rtl/wrmswl_if.sv =====
// Handshake interfaces for the input item channel and the result channel.
interface wrmswl_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] sample_0;
    logic [15:0] sample_1;
    logic [15:0] sample_2;
    logic [15:0] sample_3;

    modport source (output valid, req_type, sample_0, sample_1, sample_2, sample_3,
                    input ready);
    modport sink   (input valid, req_type, sample_0, sample_1, sample_2, sample_3,
                    output ready);
endinterface

interface wrmswl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] rms_0;
    logic [31:0] rms_1;
    logic [31:0] rms_2;
    logic [31:0] rms_3;
    logic [23:0] wl_0;
    logic [23:0] wl_1;
    logic [23:0] wl_2;
    logic [23:0] wl_3;

    modport source (output valid, status, rms_0, rms_1, rms_2, rms_3,
                    wl_0, wl_1, wl_2, wl_3, input ready);
    modport sink   (input valid, status, rms_0, rms_1, rms_2, rms_3,
                    wl_0, wl_1, wl_2, wl_3, output ready);
endinterface

// ===== rtl/wrmswl_front.sv =====
// Front end: accepts items, masks samples, classifies them and queues them.
module wrmswl_front #(
    parameter int SAMPLE_BITS = wrmswl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    wrmswl_in_if.sink           in_ch,
    output wrmswl_pkg::item_t   q_item,
    output logic                q_valid,
    input  logic                q_pop
);
    localparam logic [wrmswl_pkg::SAMPLE_W-1:0] SMASK =
        wrmswl_pkg::SAMPLE_W'((17'(1) << SAMPLE_BITS) - 17'(1));

    wrmswl_pkg::item_t mem_reg [wrmswl_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    wrmswl_pkg::item_t in_item;
    logic push;

    always_comb
    begin
        in_item.is_report = in_ch.req_type;
        in_item.smp[0]    = in_ch.sample_0 & SMASK;
        in_item.smp[1]    = in_ch.sample_1 & SMASK;
        in_item.smp[2]    = in_ch.sample_2 & SMASK;
        in_item.smp[3]    = in_ch.sample_3 & SMASK;
    end

    assign in_ch.ready = (cnt_reg != 2'(wrmswl_pkg::QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_item      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

// ===== rtl/wrmswl_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wrmswl_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wrmswl_pkg::div_req_t req,
    output wrmswl_pkg::div_rsp_t rsp
);
    localparam int NW = wrmswl_pkg::DIV_NUM_W;
    localparam int DW = wrmswl_pkg::DIV_DEN_W;

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [6:0]    cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== rtl/wrmswl_sqrt.sv =====
// Integer square root of a 64-bit value, one result bit per cycle.
module wrmswl_sqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wrmswl_pkg::sqrt_req_t req,
    output wrmswl_pkg::sqrt_rsp_t rsp
);
    localparam int W = wrmswl_pkg::SQRT_W;

    logic [W-1:0] x_reg, res_reg, bit_reg;
    logic [5:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic [W-1:0] sum;
    logic         ge;

    assign sum = res_reg + bit_reg;
    assign ge  = (x_reg >= sum);
    assign rsp.done = done_reg;
    assign rsp.root = res_reg[wrmswl_pkg::RMS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.x;
            res_reg <= '0;
            bit_reg <= W'(1) << (W - 2);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                x_reg   <= x_reg - sum;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(W / 2);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== rtl/wrmswl_back.sv =====
// Back end: window accumulation, per-channel report sequencer and result register.
module wrmswl_back #(
    parameter int CHANNELS   = wrmswl_pkg::CHANNELS_DEF,
    parameter int MAX_WINDOW = wrmswl_pkg::MAX_WINDOW_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wrmswl_pkg::item_t     q_item,
    input  logic                  q_valid,
    output logic                  q_pop,
    output wrmswl_pkg::div_req_t  div_req,
    input  wrmswl_pkg::div_rsp_t  div_rsp,
    output wrmswl_pkg::sqrt_req_t sqrt_req,
    input  wrmswl_pkg::sqrt_rsp_t sqrt_rsp,
    wrmswl_out_if.source          out_ch
);
    localparam int NCH = wrmswl_pkg::NCH;
    localparam logic [1:0] LAST = 2'(CHANNELS - 1);
    localparam logic [wrmswl_pkg::CNT_W-1:0] MAXW = wrmswl_pkg::CNT_W'(MAX_WINDOW);

    wrmswl_pkg::bstate_t state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    wrmswl_pkg::item_t item_reg, item_next;
    logic [wrmswl_pkg::SQ_W-1:0]     sq_reg [NCH], sq_next [NCH];
    logic [wrmswl_pkg::DIFF_W-1:0]   df_reg [NCH], df_next [NCH];
    logic [wrmswl_pkg::SAMPLE_W-1:0] prev_reg [NCH], prev_next [NCH];
    logic [wrmswl_pkg::BASE_W-1:0]   base_reg [NCH], base_next [NCH];
    logic [wrmswl_pkg::RMS_W-1:0]    orms_reg [NCH], orms_next [NCH];
    logic [wrmswl_pkg::WL_W-1:0]     owl_reg [NCH], owl_next [NCH];
    logic [wrmswl_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic have_prev_reg, have_prev_next;
    logic cal_reg, cal_next;
    logic allok_reg, allok_next;
    logic ovalid_reg, ovalid_next;
    wrmswl_pkg::status_t ostat_reg, ostat_next;

    logic [wrmswl_pkg::SAMPLE_W-1:0] s, p;
    logic [wrmswl_pkg::RMS_W-1:0]    root;
    logic adv;

    assign out_ch.valid  = ovalid_reg;
    assign out_ch.status = ostat_reg;
    assign out_ch.rms_0  = orms_reg[0];
    assign out_ch.rms_1  = orms_reg[1];
    assign out_ch.rms_2  = orms_reg[2];
    assign out_ch.rms_3  = orms_reg[3];
    assign out_ch.wl_0   = owl_reg[0];
    assign out_ch.wl_1   = owl_reg[1];
    assign out_ch.wl_2   = owl_reg[2];
    assign out_ch.wl_3   = owl_reg[3];

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        item_next      = item_reg;
        sq_next        = sq_reg;
        df_next        = df_reg;
        prev_next      = prev_reg;
        base_next      = base_reg;
        orms_next      = orms_reg;
        owl_next       = owl_reg;
        cnt_next       = cnt_reg;
        have_prev_next = have_prev_reg;
        cal_next       = cal_reg;
        allok_next     = allok_reg;
        ostat_next     = ostat_reg;
        ovalid_next    = ovalid_reg && !out_ch.ready;
        q_pop          = 1'b0;
        div_req        = '0;
        sqrt_req       = '0;
        adv            = 1'b0;
        s              = item_reg.smp[ch_reg];
        p              = prev_reg[ch_reg];
        root           = sqrt_rsp.root;

        case (state_reg)
            wrmswl_pkg::B_IDLE:
            begin
                if (q_valid && !q_item.is_report)
                begin
                    q_pop = 1'b1;
                    if (cnt_reg != MAXW)
                    begin
                        item_next  = q_item;
                        ch_next    = 2'd0;
                        state_next = wrmswl_pkg::B_SAMP;
                    end
                end
                else if (q_valid && !ovalid_reg)
                begin
                    q_pop = 1'b1;
                    for (int c = 0; c < NCH; c++)
                    begin
                        orms_next[c] = '0;
                        owl_next[c]  = '0;
                    end
                    if (cnt_reg == '0)
                    begin
                        ostat_next     = wrmswl_pkg::ST_EMPTY;
                        ovalid_next    = 1'b1;
                        have_prev_next = 1'b0;
                    end
                    else
                    begin
                        ch_next    = 2'd0;
                        allok_next = 1'b1;
                        state_next = wrmswl_pkg::B_LAUNCH;
                    end
                end
            end
            wrmswl_pkg::B_SAMP:
            begin
                sq_next[ch_reg] = sq_reg[ch_reg]
                    + wrmswl_pkg::SQ_W'(32'(s) * 32'(s));
                if (have_prev_reg)
                begin
                    df_next[ch_reg] = df_reg[ch_reg]
                        + wrmswl_pkg::DIFF_W'((s > p) ? s - p : p - s);
                end
                prev_next[ch_reg] = s;
                if (ch_reg == LAST)
                begin
                    have_prev_next = 1'b1;
                    cnt_next       = cnt_reg + wrmswl_pkg::CNT_W'(1);
                    state_next     = wrmswl_pkg::B_IDLE;
                end
                else
                begin
                    ch_next = ch_reg + 2'd1;
                end
            end
            wrmswl_pkg::B_LAUNCH:
            begin
                div_req.start = 1'b1;
                div_req.num   = wrmswl_pkg::DIV_NUM_W'({df_reg[ch_reg], 8'd0});
                div_req.den   = wrmswl_pkg::DIV_DEN_W'(cnt_reg);
                state_next    = wrmswl_pkg::B_WLDIV;
            end
            wrmswl_pkg::B_WLDIV:
            begin
                if (div_rsp.done)
                begin
                    owl_next[ch_reg] = (|div_rsp.quot[wrmswl_pkg::DIV_NUM_W-1:wrmswl_pkg::WL_W])
                        ? '1 : div_rsp.quot[wrmswl_pkg::WL_W-1:0];
                    div_req.start = 1'b1;
                    div_req.num   = {sq_reg[ch_reg], 32'd0};
                    div_req.den   = wrmswl_pkg::DIV_DEN_W'(cnt_reg);
                    state_next    = wrmswl_pkg::B_MDIV;
                end
            end
            wrmswl_pkg::B_MDIV:
            begin
                if (div_rsp.done)
                begin
                    sqrt_req.start = 1'b1;
                    sqrt_req.x     = div_rsp.quot[wrmswl_pkg::SQRT_W-1:0];
                    state_next     = wrmswl_pkg::B_SQRT;
                end
            end
            wrmswl_pkg::B_SQRT:
            begin
                if (sqrt_rsp.done)
                begin
                    if (!cal_reg)
                    begin
                        base_next[ch_reg] = root[wrmswl_pkg::RMS_W-1:8];
                        orms_next[ch_reg] = root;
                        if (root[wrmswl_pkg::RMS_W-1:8] == '0)
                        begin
                            allok_next = 1'b0;
                        end
                        adv = 1'b1;
                    end
                    else if (base_reg[ch_reg] == '0)
                    begin
                        orms_next[ch_reg] = '1;
                        adv = 1'b1;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = wrmswl_pkg::DIV_NUM_W'({root, 8'd0});
                        div_req.den   = base_reg[ch_reg];
                        state_next    = wrmswl_pkg::B_RDIV;
                    end
                end
            end
            wrmswl_pkg::B_RDIV:
            begin
                if (div_rsp.done)
                begin
                    orms_next[ch_reg] =
                        (|div_rsp.quot[wrmswl_pkg::DIV_NUM_W-1:wrmswl_pkg::RMS_W])
                        ? '1 : div_rsp.quot[wrmswl_pkg::RMS_W-1:0];
                    adv = 1'b1;
                end
            end
            wrmswl_pkg::B_DONE:
            begin
                if (!cal_reg)
                begin
                    cal_next   = allok_reg;
                    ostat_next = allok_reg ? wrmswl_pkg::ST_CAL_NOW
                                           : wrmswl_pkg::ST_CAL_RETRY;
                end
                else
                begin
                    ostat_next = wrmswl_pkg::ST_MEAS;
                end
                for (int c = 0; c < NCH; c++)
                begin
                    sq_next[c] = '0;
                    df_next[c] = '0;
                end
                cnt_next       = '0;
                have_prev_next = 1'b0;
                ovalid_next    = 1'b1;
                state_next     = wrmswl_pkg::B_IDLE;
            end
            default:
            begin
                state_next = wrmswl_pkg::B_IDLE;
            end
        endcase

        if (adv)
        begin
            if (ch_reg == LAST)
            begin
                state_next = wrmswl_pkg::B_DONE;
            end
            else
            begin
                ch_next    = ch_reg + 2'd1;
                state_next = wrmswl_pkg::B_LAUNCH;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        orms_reg <= orms_next;
        owl_reg  <= owl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrmswl_pkg::B_IDLE;
            ch_reg        <= 2'd0;
            cnt_reg       <= '0;
            have_prev_reg <= 1'b0;
            cal_reg       <= 1'b0;
            allok_reg     <= 1'b0;
            ovalid_reg    <= 1'b0;
            ostat_reg     <= wrmswl_pkg::ST_EMPTY;
            for (int c = 0; c < NCH; c++)
            begin
                sq_reg[c]   <= '0;
                df_reg[c]   <= '0;
                prev_reg[c] <= '0;
                base_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            have_prev_reg <= have_prev_next;
            cal_reg       <= cal_next;
            allok_reg     <= allok_next;
            ovalid_reg    <= ovalid_next;
            ostat_reg     <= ostat_next;
            sq_reg        <= sq_next;
            df_reg        <= df_next;
            prev_reg      <= prev_next;
            base_reg      <= base_next;
        end
    end
endmodule

// ===== rtl/windowed_rms_waveform_length_core.sv =====
// Top level of the four-channel windowed RMS and waveform length feature core.
//
//   channel  | dir | payload                                  | handshake
//   ---------+-----+------------------------------------------+-------------
//   in_ch    | in  | req_type, sample_0..sample_3             | valid/ready
//   out_ch   | out | status, rms_0..rms_3, wl_0..wl_3         | valid/ready
//
// A sample item is taken in the back end one active channel at a time (one
// 16x16 multiply and accumulate per cycle), through the sample state and back
// to idle before the next item. A window-end item runs per channel: a launch
// state, an 80-step waveform length divide, an 80-step mean-square divide,
// a 32-step square root and, once calibrated, an 80-step ratio divide; the
// divides share one divider. An empty window is answered from idle with
// status empty.
// Reset clears all window sums, calibration state and the two-entry queue.
// The queue keeps taking items, up to its two entries, while the back end is busy; a finished
// result waits in the output register while sample items keep flowing, and
// the next window-end item holds until that result is taken.
module windowed_rms_waveform_length_core #(
    parameter int CHANNELS    = wrmswl_pkg::CHANNELS_DEF,
    parameter int MAX_WINDOW  = wrmswl_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wrmswl_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    wrmswl_in_if.sink     in_ch,
    wrmswl_out_if.source  out_ch
);
    wrmswl_pkg::item_t     q_item;
    logic                  q_valid;
    logic                  q_pop;
    wrmswl_pkg::div_req_t  div_req;
    wrmswl_pkg::div_rsp_t  div_rsp;
    wrmswl_pkg::sqrt_req_t sqrt_req;
    wrmswl_pkg::sqrt_rsp_t sqrt_rsp;

    // item intake and queue
    wrmswl_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // shared serial divider
    wrmswl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // serial square root
    wrmswl_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // accumulation and report sequencer
    wrmswl_back #(
        .CHANNELS   (CHANNELS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .sqrt_req (sqrt_req),
        .sqrt_rsp (sqrt_rsp),
        .out_ch   (out_ch)
    );
endmodule

// ===== rtl/wrmswl_checker.sv =====
// Port-level checks on the core's result channel, bound to the top level.
module wrmswl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] rms_0,
    input logic [31:0] rms_3,
    input logic [23:0] wl_0,
    input logic [23:0] wl_3
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(rms_0) && $stable(wl_0))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == wrmswl_pkg::ST_EMPTY
        |-> rms_0 == '0 && wl_0 == '0 && rms_3 == '0 && wl_3 == '0)
        else $error("empty window result carries nonzero features");
endmodule

bind windowed_rms_waveform_length_core wrmswl_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (out_ch.status),
    .rms_0     (out_ch.rms_0),
    .rms_3     (out_ch.rms_3),
    .wl_0      (out_ch.wl_0),
    .wl_3      (out_ch.wl_3)
);
